@@ rtl/two_way_traffic_light_sequencer_top_assert.svh @@
// assertion macros shared by the traffic light sequencer modules
`ifndef TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_TOP_ASSERT_SVH
`define TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_TOP_ASSERT_SVH

// property checked every clock, muted while reset is applied
`define TLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define TLS_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) else $error(msg);

`endif

@@ rtl/tls_pkg.sv @@
// shared constants, types and the step table of the traffic light sequencer
package tls_pkg;

	localparam int NUM_STEPS = 26;
	localparam int STEP_W    = 5;
	localparam int ELAPSED_W = 20;
	localparam int EL_IN_W   = 16;
	localparam int POT_W     = 10;
	localparam int MAX_W     = 8;
	localparam int UNIT_W    = 10;
	localparam int BASE_W    = 4;
	localparam int LAMP_W    = 6;
	localparam int PROD_W    = POT_W + MAX_W;
	localparam int EXTRA_W   = MAX_W;
	localparam int DUR_W     = EXTRA_W + 1;
	localparam int THR_W     = DUR_W + UNIT_W;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;

	localparam logic [POT_W-1:0] POT_FULL = {POT_W{1'b1}};

	localparam logic [STEP_W-1:0] NORM_START  = STEP_W'(0);
	localparam logic [STEP_W-1:0] NORM_LAST   = STEP_W'(NUM_STEPS - 3);
	localparam logic [STEP_W-1:0] BLINK_START = STEP_W'(NUM_STEPS - 2);
	localparam logic [STEP_W-1:0] BLINK_LAST  = STEP_W'(NUM_STEPS - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VAR = 2'd1;

	localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd100;
	localparam logic [MAX_W-1:0]  MAX_RESET  = 8'd20;

	typedef enum logic [1:0] {
		POT_NONE = 2'd0,
		POT_ONE  = 2'd1,
		POT_TWO  = 2'd2
	} pot_sel_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		pot_sel_t          pot_sel;
		logic [LAMP_W-1:0] lamps;
	} step_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic dur;
		logic thr;
		logic upd;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	function automatic step_entry_t mk(input logic [BASE_W-1:0] b, input pot_sel_t p,
			input logic [LAMP_W-1:0] l);
		step_entry_t e;
		e.base    = b;
		e.pot_sel = p;
		e.lamps   = l;
		return e;
	endfunction

	// lamp bits: red_one, yellow_one, green_one, red_two, yellow_two, green_two
	function automatic step_entry_t step_lookup(input logic [STEP_W-1:0] idx);
		step_entry_t e;
		unique case (idx)
			5'd0:    e = mk(4'd10, POT_ONE,  6'd12);
			5'd1:    e = mk(4'd1,  POT_NONE, 6'd8);
			5'd2:    e = mk(4'd1,  POT_NONE, 6'd12);
			5'd3:    e = mk(4'd1,  POT_NONE, 6'd8);
			5'd4:    e = mk(4'd1,  POT_NONE, 6'd12);
			5'd5:    e = mk(4'd1,  POT_NONE, 6'd8);
			5'd6:    e = mk(4'd1,  POT_NONE, 6'd12);
			5'd7:    e = mk(4'd1,  POT_NONE, 6'd8);
			5'd8:    e = mk(4'd1,  POT_NONE, 6'd12);
			5'd9:    e = mk(4'd4,  POT_NONE, 6'd10);
			5'd10:   e = mk(4'd2,  POT_NONE, 6'd9);
			5'd11:   e = mk(4'd4,  POT_NONE, 6'd25);
			5'd12:   e = mk(4'd10, POT_TWO,  6'd33);
			5'd13:   e = mk(4'd1,  POT_NONE, 6'd1);
			5'd14:   e = mk(4'd1,  POT_NONE, 6'd33);
			5'd15:   e = mk(4'd1,  POT_NONE, 6'd1);
			5'd16:   e = mk(4'd1,  POT_NONE, 6'd33);
			5'd17:   e = mk(4'd1,  POT_NONE, 6'd1);
			5'd18:   e = mk(4'd1,  POT_NONE, 6'd33);
			5'd19:   e = mk(4'd1,  POT_NONE, 6'd1);
			5'd20:   e = mk(4'd1,  POT_NONE, 6'd33);
			5'd21:   e = mk(4'd4,  POT_NONE, 6'd17);
			5'd22:   e = mk(4'd2,  POT_NONE, 6'd9);
			5'd23:   e = mk(4'd4,  POT_NONE, 6'd11);
			5'd24:   e = mk(4'd1,  POT_NONE, 6'd2);
			5'd25:   e = mk(4'd1,  POT_NONE, 6'd16);
			default: e = mk(4'd1,  POT_NONE, 6'd16);
		endcase
		return e;
	endfunction

endpackage

@@ rtl/tls_dp.sv @@
// datapath: config registers, sequencer state, duration arithmetic, result register
module tls_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tls_pkg::dp_cmd_t              cmd,
	output tls_pkg::dp_sts_t              sts,
	input  logic [tls_pkg::IN_W-1:0]      in_data,
	input  logic                          cfg_we,
	input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tls_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tls_pkg::OUT_W-1:0]     out_data
);

	// configuration
	logic [tls_pkg::UNIT_W-1:0] unit_q;
	logic [tls_pkg::MAX_W-1:0]  max_q;

	// sequencer state
	logic [tls_pkg::STEP_W-1:0]    step_q;
	logic                          mode_q;
	logic [tls_pkg::ELAPSED_W-1:0] count_q;
	logic                          btn_prev_q;
	logic [tls_pkg::LAMP_W-1:0]    lamp_q;

	// per-item working registers
	logic [tls_pkg::EL_IN_W-1:0]   el_q;
	logic                          btn_q;
	logic [tls_pkg::POT_W-1:0]     pot_q;
	logic [tls_pkg::PROD_W-1:0]    prod_q;
	logic [tls_pkg::ELAPSED_W-1:0] sum_q;
	logic [tls_pkg::DUR_W-1:0]     dur_q;
	logic [tls_pkg::THR_W-1:0]     thr_q;

	logic                          out_valid_q;
	logic [tls_pkg::OUT_W-1:0]     out_data_q;

	tls_pkg::step_entry_t          cur_e;
	tls_pkg::step_entry_t          nxt_e;
	logic [tls_pkg::ELAPSED_W:0]   sum_wide;
	logic [tls_pkg::EXTRA_W-1:0]   quo0;
	logic [tls_pkg::POT_W:0]       rem;
	logic [tls_pkg::EXTRA_W-1:0]   extra;
	logic                          adv;
	logic                          toggle;
	logic [tls_pkg::STEP_W-1:0]    step_inc;
	logic [tls_pkg::STEP_W-1:0]    step_adv;
	logic [tls_pkg::STEP_W-1:0]    step_new;
	logic                          mode_new;
	logic [tls_pkg::ELAPSED_W-1:0] count_new;
	logic [tls_pkg::LAMP_W-1:0]    lamp_new;

	assign cur_e = tls_pkg::step_lookup(step_q);

	// saturating counter add
	assign sum_wide = {1'b0, count_q} + {{(tls_pkg::ELAPSED_W + 1 - tls_pkg::EL_IN_W){1'b0}}, el_q};

	// divide by full scale: q0 = p >> 10, remainder = low bits + q0, one correction
	assign quo0  = prod_q[tls_pkg::PROD_W-1:tls_pkg::POT_W];
	assign rem   = {1'b0, prod_q[tls_pkg::POT_W-1:0]}
		+ {{(tls_pkg::POT_W + 1 - tls_pkg::EXTRA_W){1'b0}}, quo0};
	assign extra = quo0 + tls_pkg::EXTRA_W'(rem >= {1'b0, tls_pkg::POT_FULL});

	// step update
	assign adv      = {{(tls_pkg::ELAPSED_W - tls_pkg::THR_W){1'b0}}, thr_q} <= sum_q;
	assign toggle   = !btn_q && btn_prev_q;
	assign step_inc = step_q + tls_pkg::STEP_W'(1);

	always_comb begin
		if (mode_q) begin
			step_adv = (step_inc > tls_pkg::BLINK_LAST || step_inc < tls_pkg::BLINK_START)
				? tls_pkg::BLINK_START : step_inc;
		end else begin
			step_adv = (step_inc > tls_pkg::NORM_LAST) ? tls_pkg::NORM_START : step_inc;
		end
	end

	assign nxt_e = tls_pkg::step_lookup(step_adv);

	always_comb begin
		step_new  = step_q;
		mode_new  = mode_q;
		count_new = sum_q;
		lamp_new  = lamp_q;
		if (adv) begin
			step_new  = step_adv;
			lamp_new  = nxt_e.lamps;
			count_new = '0;
		end
		if (toggle) begin
			mode_new  = !mode_q;
			step_new  = mode_q ? tls_pkg::NORM_LAST : tls_pkg::BLINK_LAST;
			lamp_new  = '0;
			count_new = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= tls_pkg::UNIT_RESET;
			max_q  <= tls_pkg::MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tls_pkg::CFG_UNIT_MS: unit_q <= cfg_data[tls_pkg::UNIT_W-1:0];
				tls_pkg::CFG_MAX_VAR: max_q  <= cfg_data[tls_pkg::MAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= tls_pkg::BLINK_LAST;
			mode_q     <= 1'b1;
			count_q    <= '1;
			btn_prev_q <= 1'b1;
			lamp_q     <= '0;
		end else if (cmd.upd) begin
			step_q     <= step_new;
			mode_q     <= mode_new;
			count_q    <= count_new;
			btn_prev_q <= btn_q;
			lamp_q     <= lamp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			el_q  <= in_data[15:0];
			btn_q <= in_data[16];
			unique case (cur_e.pot_sel)
				tls_pkg::POT_ONE: pot_q <= in_data[26:17];
				tls_pkg::POT_TWO: pot_q <= in_data[36:27];
				default:          pot_q <= '0;
			endcase
		end
		if (cmd.mul) begin
			prod_q <= pot_q * max_q;
			sum_q  <= sum_wide[tls_pkg::ELAPSED_W] ? '1 : sum_wide[tls_pkg::ELAPSED_W-1:0];
		end
		if (cmd.dur) begin
			dur_q <= {{(tls_pkg::DUR_W - tls_pkg::BASE_W){1'b0}}, cur_e.base}
				+ {1'b0, extra};
		end
		if (cmd.thr) begin
			thr_q <= dur_q * unit_q;
		end
		if (cmd.upd) begin
			out_data_q <= {3'b000, adv, mode_new, step_new, lamp_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	`include "two_way_traffic_light_sequencer_top_assert.svh"

	`TLS_ASSERT(a_step_in_range, (mode_q ? (step_q >= tls_pkg::BLINK_START && step_q <= tls_pkg::BLINK_LAST) : (step_q <= tls_pkg::NORM_LAST)), "step outside the range of its mode")
	`TLS_ASSERT_NEXT(a_upd_shows, cmd.upd, out_valid, "update did not load the result register")
	`TLS_ASSERT_NEXT(a_adv_clears, cmd.upd && adv && !toggle, count_q == '0, "advance left the counter running")
	`TLS_ASSERT_NEXT(a_toggle_dark, cmd.upd && toggle, lamp_q == '0 && count_q == '1, "toggle did not park the lamps")

endmodule

@@ rtl/tls_ctrl.sv @@
// controller: sequences one item through the datapath stages
module tls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tls_pkg::dp_sts_t  sts,
	output tls_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DUR  = 3'd2;
	localparam logic [2:0] S_THR  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_DUR;
			end
			S_DUR: begin
				cmd.dur   = 1'b1;
				state_nxt = S_THR;
			end
			S_THR: begin
				cmd.thr   = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				// hold here while the previous result is still waiting
				cmd.upd = !sts.out_busy;
				if (!sts.out_busy) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`include "two_way_traffic_light_sequencer_top_assert.svh"

	`TLS_ASSERT(a_cmd_single, $onehot0({cmd.load, cmd.mul, cmd.dur, cmd.thr, cmd.upd}), "more than one datapath command")
	`TLS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accepted a second item mid-pass")
	`TLS_ASSERT_NEXT(a_upd_frees, cmd.upd, in_ready, "controller not free after update")

endmodule

@@ rtl/two_way_traffic_light_sequencer_top.sv @@
// top level of the two-way traffic light sequencer
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  elapsed_ms, mode_button, pot_one, pot_two
// m_axis    out  m_axis_tvalid / m_axis_tready  six lamps, step_now, blink_mode, step_advanced
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// an item goes from accept to result in this order: accept, pot multiply, divide by
//   full scale plus base add, duration times unit multiply, compare and state update
// the two multipliers are used one after the other, so one item is in work at a time
// the next item is taken while a result still sits in the output register
// if the output is stalled, the update waits until the held result is taken
// reset: blinking mode, last blinking step, lamps off, full counter; unit 100, max green 20
module two_way_traffic_light_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// item in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// elapsed_ms[15:0], mode_button[16], pot_one[26:17], pot_two[36:27], zero fill
	input  logic [tls_pkg::IN_W-1:0]      s_axis_tdata,
	// item out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// red_one[0], yellow_one[1], green_one[2], red_two[3], yellow_two[4],
	// green_two[5], step_now[10:6], blink_mode[11], step_advanced[12], zero fill
	output logic [tls_pkg::OUT_W-1:0]     m_axis_tdata,
	// register writes: index 0 unit_ms, index 1 max_green_units, others ignored
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tls_pkg::CFG_DAT_W-1:0] cfg_data
);

	tls_pkg::dp_cmd_t cmd;
	tls_pkg::dp_sts_t sts;

	// writes are to arrive only while idle; the block does not enforce this and always takes them
	assign cfg_ready = 1'b1;

	tls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
